FILE: design/idq_pkg.sv
// Shared constants, codes and types for the indexed double-ended queue.
// Used by idq_ctrl and the indexed_double_ended_queue top level.
package idq_pkg;

   // Storage geometry
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int CMD_W = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 6;
   localparam int STS_W = 2;
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd5;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CAPTURE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   // One finished result
   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [STS_W-1:0]        status;
      logic [CNT_W-1:0]        occupancy;
   } result_type;

   // Entry store access from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

FILE: design/idq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module idq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/idq_ctrl.sv
// Command sequencer for the indexed double-ended queue: ring pointers,
// the shared slot adder and the removal shift loop. Uses idq_pkg.
module idq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [idq_pkg::CMD_W-1:0]      req_cmd,
   input  logic [idq_pkg::VAL_W-1:0]      req_value,
   input  logic [idq_pkg::POS_W-1:0]      req_pos,
   input  logic                           out_free,
   output logic                           res_valid,
   output idq_pkg::result_type            res,
   output idq_pkg::ram_req_type           ram_req,
   input  logic [idq_pkg::VAL_W-1:0]      ram_rd_data
);
   import idq_pkg::*;

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] hole_ff, hole_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [VAL_W-1:0] rd_val_ff, rd_val_in;
   logic [STS_W-1:0] status_ff, status_in;
   logic             use_ram_ff, use_ram_in;

   logic             req_fire;
   logic             empty;
   logic             full;
   logic             beyond;
   logic             more;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] idx_p1;
   logic [PTR_W-1:0] rem_off;
   logic [PTR_W-1:0] offset;
   logic [PTR_W:0]   slot_sum;
   logic [PTR_W-1:0] slot;

   assign req_fire = req_valid && req_ready;

   // Status of the held entries
   assign empty    = (count_ff == '0);
   assign full     = (count_ff >= CNT_W'(DEPTH));
   assign beyond   = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
   assign count_m1 = count_ff - CNT_W'(1);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign more     = (idx_p1 < count_ff);
   // Removal past the end takes the last entry
   assign rem_off  = beyond ? PTR_W'(count_m1) : PTR_W'(pos_ff);

   // Offset select for the shared slot adder
   always_comb begin
      offset = '0;
      if (state_ff == ST_SHIFT_RD) begin
         offset = PTR_W'(idx_p1);
      end else begin
         case (cmd_ff)
            CMD_PUSH_FRONT: offset = PTR_W'(DEPTH - 1);
            CMD_PUSH_BACK:  offset = PTR_W'(count_ff);
            CMD_POP_FRONT:  offset = PTR_W'(1);
            CMD_POP_BACK:   offset = PTR_W'(count_m1);
            CMD_READ_AT:    offset = PTR_W'(pos_ff);
            CMD_REMOVE_AT:  offset = rem_off;
            default:        offset = '0;
         endcase
      end
   end

   // Shared slot adder: (front + offset) mod DEPTH
   assign slot_sum = {1'b0, front_ff} + {1'b0, offset};
   assign slot     = (slot_sum >= (PTR_W+1)'(DEPTH))
                     ? PTR_W'(slot_sum - (PTR_W+1)'(DEPTH))
                     : PTR_W'(slot_sum);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_REMOVE_AT && !empty) state_in = ST_CAPTURE;
            else                                    state_in = ST_DONE;
         end
         ST_CAPTURE:  state_in = ST_SHIFT_RD;
         ST_SHIFT_RD: state_in = more ? ST_SHIFT_WR : ST_DONE;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_DONE: begin
            if (out_free) state_in = req_fire ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and entry store access
   always_comb begin
      req_ready       = 1'b0;
      res_valid       = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = slot;
      ram_req.wr_data = value_ff;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = slot;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: begin
            case (cmd_ff)
               CMD_PUSH_FRONT,
               CMD_PUSH_BACK: ram_req.wr_en = !full;
               CMD_POP_FRONT: begin
                  ram_req.rd_en   = !empty;
                  ram_req.rd_addr = front_ff;
               end
               CMD_POP_BACK,
               CMD_REMOVE_AT: ram_req.rd_en = !empty;
               CMD_READ_AT:   ram_req.rd_en = !empty && !beyond;
               default: ;
            endcase
         end
         ST_SHIFT_RD: ram_req.rd_en = more;
         ST_SHIFT_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = hole_ff;
            ram_req.wr_data = ram_rd_data;
         end
         ST_DONE: begin
            res_valid = out_free;
            req_ready = out_free;
         end
         default: ;
      endcase
   end

   // Datapath register updates
   always_comb begin
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      hole_in    = hole_ff;
      next_in    = next_ff;
      rd_val_in  = rd_val_ff;
      status_in  = status_ff;
      use_ram_in = use_ram_ff;

      if (req_fire) begin
         cmd_in   = req_cmd;
         value_in = req_value;
         pos_in   = req_pos;
      end

      case (state_ff)
         ST_EXEC: begin
            rd_val_in  = '0;
            status_in  = STS_OK;
            use_ram_in = 1'b0;
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  if (full) begin
                     status_in = STS_FULL;
                  end else begin
                     front_in = slot;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_PUSH_BACK: begin
                  if (full) status_in = STS_FULL;
                  else      count_in  = count_ff + CNT_W'(1);
               end
               CMD_POP_FRONT: begin
                  if (empty) begin
                     status_in = STS_EMPTY;
                  end else begin
                     use_ram_in = 1'b1;
                     front_in   = slot;
                     count_in   = count_m1;
                  end
               end
               CMD_POP_BACK: begin
                  if (empty) begin
                     status_in = STS_EMPTY;
                  end else begin
                     use_ram_in = 1'b1;
                     count_in   = count_m1;
                  end
               end
               CMD_READ_AT: begin
                  if (empty)       status_in  = STS_EMPTY;
                  else if (beyond) status_in  = STS_RANGE;
                  else             use_ram_in = 1'b1;
               end
               CMD_REMOVE_AT: begin
                  if (empty) begin
                     status_in = STS_EMPTY;
                  end else begin
                     idx_in  = CNT_W'(rem_off);
                     hole_in = slot;
                  end
               end
               default: ;
            endcase
         end
         ST_CAPTURE: rd_val_in = ram_rd_data;
         ST_SHIFT_RD: begin
            if (more) next_in  = slot;
            else      count_in = count_m1;
         end
         ST_SHIFT_WR: begin
            hole_in = next_ff;
            idx_in  = idx_p1;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      hole_ff    <= hole_in;
      next_ff    <= next_in;
      rd_val_ff  <= rd_val_in;
      status_ff  <= status_in;
      use_ram_ff <= use_ram_in;
   end

   // Result; pops and reads take the word straight from the store
   assign res.read_value = use_ram_ff ? ram_rd_data : rd_val_ff;
   assign res.status     = status_ff;
   assign res.occupancy  = count_ff;

endmodule

FILE: design/indexed_double_ended_queue.sv
// Indexed double-ended queue: 64 signed words in a ring buffer in one RAM.
// Pushes, pops and reads pass EXEC then DONE; a removal adds CAPTURE and a
// SHIFT_RD/SHIFT_WR pair per later entry moved. One command at a time: a
// new request is taken only when idle or as the last result enters the
// output register; one RAM port pair and one adder move entries singly.
// Reset: synchronous; empties the queue, the store itself is not cleared.
module indexed_double_ended_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // value [31:0], position [37:32], zero fill above
   input  logic [idq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command [2:0]
   input  logic [idq_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], occupancy [38:32], zero fill above
   output logic [idq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [idq_pkg::STS_W-1:0]        rsp_tuser
);
   import idq_pkg::*;

   logic        out_free;
   logic        res_valid;
   result_type  res;
   ram_req_type ram_req;
   logic [VAL_W-1:0] ram_rd_data;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   // Sequencer
   idq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_value   (req_tdata[VAL_W-1:0]),
      .req_pos     (req_tdata[VAL_W+POS_W-1:VAL_W]),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   // Entry store
   idq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: takes a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_W-VAL_W-CNT_W){1'b0}},
                        rsp_data_ff.occupancy, rsp_data_ff.read_value};

endmodule

FILE: verif/indexed_double_ended_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_double_ended_queue: drives command
// transfers, predicts every result with its own deque model and compares.
// Depends on idq_pkg and the indexed_double_ended_queue top level.
module indexed_double_ended_queue_test;
   import idq_pkg::*;

   localparam int RANDOM_ITEMS_PER_PHASE = 488;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   // Deque predictor plus the queue of results still owed by the block
   class deque_scoreboard;
      logic [VAL_W-1:0] entry_store [DEPTH];
      logic [PTR_W-1:0] front_slot = '0;
      logic [CNT_W-1:0] entry_count = '0;
      result_type       expected_results [$];
      int               mismatch_count = 0;
      int               result_index = 0;

      function logic [PTR_W-1:0] ring_slot(logic [CNT_W-1:0] offset);
         return front_slot + offset[PTR_W-1:0];
      endfunction

      // Apply one accepted command to the model and queue its result
      function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                                 logic [POS_W-1:0] position);
         result_type       outcome;
         logic [CNT_W-1:0] idx;
         outcome = '0;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (entry_count >= DEPTH) begin
                  outcome.status = STS_FULL;
               end else if (cmd == CMD_PUSH_FRONT) begin
                  front_slot = front_slot - 1'b1;
                  entry_store[front_slot] = value;
                  entry_count++;
               end else begin
                  entry_store[ring_slot(entry_count)] = value;
                  entry_count++;
               end
            end
            CMD_POP_FRONT: begin
               if (entry_count == 0) begin
                  outcome.status = STS_EMPTY;
               end else begin
                  outcome.read_value = entry_store[front_slot];
                  front_slot = front_slot + 1'b1;
                  entry_count--;
               end
            end
            CMD_POP_BACK: begin
               if (entry_count == 0) begin
                  outcome.status = STS_EMPTY;
               end else begin
                  outcome.read_value = entry_store[ring_slot(entry_count - 1'b1)];
                  entry_count--;
               end
            end
            CMD_READ_AT: begin
               if (entry_count == 0) begin
                  outcome.status = STS_EMPTY;
               end else if (CNT_W'(position) >= entry_count) begin
                  outcome.status = STS_RANGE;
               end else begin
                  outcome.read_value = entry_store[ring_slot(CNT_W'(position))];
               end
            end
            CMD_REMOVE_AT: begin
               if (entry_count == 0) begin
                  outcome.status = STS_EMPTY;
               end else begin
                  // past the end means the last entry
                  idx = CNT_W'(position);
                  if (idx >= entry_count) idx = entry_count - 1'b1;
                  outcome.read_value = entry_store[ring_slot(idx)];
                  while (idx + 1'b1 < entry_count) begin
                     entry_store[ring_slot(idx)] = entry_store[ring_slot(idx + 1'b1)];
                     idx++;
                  end
                  entry_count--;
               end
            end
            default: ;
         endcase
         outcome.occupancy = entry_count;
         expected_results.push_back(outcome);
      endfunction

      task report_mismatch(string what, logic [VAL_W-1:0] got,
                           logic [VAL_W-1:0] want);
         $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                  result_index, what, got, want);
         mismatch_count++;
      endtask

      // Compare one result transfer against the oldest expectation
      task check_result(logic [VAL_W-1:0] read_value, logic [STS_W-1:0] status,
                        logic [CNT_W-1:0] occupancy);
         result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer, read_value", read_value, '0);
         end else begin
            want = expected_results.pop_front();
            if (read_value !== want.read_value)
               report_mismatch("read_value", read_value, want.read_value);
            if (status !== want.status)
               report_mismatch("status", VAL_W'(status), VAL_W'(want.status));
            if (occupancy !== want.occupancy)
               report_mismatch("occupancy", VAL_W'(occupancy), VAL_W'(want.occupancy));
         end
         result_index++;
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // value [31:0], position [37:32], zero fill above
   logic [REQ_DATA_W-1:0] req_tdata;
   // command [2:0]
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // read_value [31:0], occupancy [38:32], zero fill above
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STS_W-1:0]      rsp_tuser;

   deque_scoreboard sb;
   int unsigned     send_idle_pct;
   int unsigned     recv_stall_pct;
   int              idle_cycles;

   indexed_double_ended_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[VAL_W-1:0], rsp_tuser, rsp_tdata[VAL_W +: CNT_W]);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("indexed_double_ended_queue_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One command transfer, with random sender gaps ahead of it
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                               logic [POS_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - VAL_W - POS_W){1'b0}}, position, value};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, value, position);
   endtask

   // Random commands in runs that lean toward filling, draining or neither
   task automatic send_random(int count);
      int unsigned      weights [3][6] = '{'{35, 70, 78, 84, 92, 98},
                                           '{8, 16, 38, 60, 75, 98},
                                           '{17, 34, 48, 62, 82, 98}};
      int               run_left;
      int               lean;
      int unsigned      pick;
      logic [CMD_W-1:0] cmd;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      run_left = 0;
      lean = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(80, 20);
            lean = $urandom_range(2);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < weights[lean][0]) cmd = CMD_PUSH_FRONT;
         else if (pick < weights[lean][1]) cmd = CMD_PUSH_BACK;
         else if (pick < weights[lean][2]) cmd = CMD_POP_FRONT;
         else if (pick < weights[lean][3]) cmd = CMD_POP_BACK;
         else if (pick < weights[lean][4]) cmd = CMD_READ_AT;
         else if (pick < weights[lean][5]) cmd = CMD_REMOVE_AT;
         else cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
         // extreme words now and then
         case ($urandom_range(19))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h0000_0000;
            3: value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase
         // mostly in range, some at the boundary, some anywhere
         pick = $urandom_range(99);
         if (pick < 65 && sb.entry_count != 0)
            position = POS_W'($urandom_range(sb.entry_count - 1));
         else if (pick < 80 && sb.entry_count != 0)
            position = POS_W'(sb.entry_count - $urandom_range(1));
         else
            position = POS_W'($urandom_range(DEPTH - 1));
         send_command(cmd, value, position);
      end
   endtask

   initial begin
      sb = new();
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_PUSH_FRONT;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty errors, spare codes, extremes, range and removal cases
      send_command(CMD_POP_FRONT, '0, '0);
      send_command(CMD_POP_BACK, '0, '0);
      send_command(CMD_READ_AT, '0, '0);
      send_command(CMD_REMOVE_AT, '0, 6'd63);
      send_command(CMD_SPARE_6, 32'hFFFF_FFFF, 6'd63);
      send_command(CMD_SPARE_7, '0, '0);
      send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF, '0);
      send_command(CMD_PUSH_BACK, 32'h8000_0000, 6'd63);
      send_command(CMD_PUSH_FRONT, 32'h0000_0000, '0);
      send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 6'd42);
      send_command(CMD_PUSH_BACK, 32'hA5A5_A5A5, 6'd21);
      send_command(CMD_PUSH_FRONT, 32'h5A5A_5A5A, '0);
      send_command(CMD_READ_AT, '0, '0);
      send_command(CMD_READ_AT, '0, 6'd5);
      send_command(CMD_READ_AT, '0, 6'd6);
      send_command(CMD_READ_AT, 32'hFFFF_FFFF, 6'd63);
      send_command(CMD_REMOVE_AT, '0, 6'd2);
      send_command(CMD_REMOVE_AT, '0, 6'd63);
      send_command(CMD_REMOVE_AT, '0, '0);
      send_command(CMD_SPARE_6, '0, 6'd1);
      send_command(CMD_POP_FRONT, '0, '0);
      send_command(CMD_POP_BACK, '0, '0);
      send_command(CMD_POP_BACK, '0, '0);
      send_command(CMD_POP_FRONT, '0, '0);

      // Random phases with different gap patterns
      send_random(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 79;
      send_random(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 0;
      recv_stall_pct = 79;
      send_random(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 19;
      recv_stall_pct = 19;
      send_random(RANDOM_ITEMS_PER_PHASE);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0)
         $display("indexed_double_ended_queue_test OK");
      else
         $display("indexed_double_ended_queue_test NOT OK");
      $finish;
   end

endmodule
